// ===== rtl/ntt_pkg.sv =====
// shared constants and request codes for the number theoretic transform engine
// no dependencies
package ntt_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned CFG_IDX_W = 1;

	// prime modulus 17*2^27+1 and its primitive root
	localparam logic [DATA_W-1:0] MODULUS = 32'd2281701377;
	localparam logic [DATA_W-1:0] ROOT = 32'd3;
	localparam logic [DATA_W-1:0] ROOT_ODD = 32'd17;
	localparam int unsigned TWO_ADIC = 27;

	typedef logic [1:0] req_code_t;
	localparam req_code_t REQ_LOAD = 2'd0;
	localparam req_code_t REQ_XFORM = 2'd1;
	localparam req_code_t REQ_READ = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_INVERSE = 1'd0;
	localparam cfg_idx_t CFG_LOG_SIZE = 1'd1;

endpackage

// ===== rtl/ntt_ifs.sv =====
// handshake channels of the transform engine: request, response and config write
// depends on ntt_pkg
interface ntt_req_if;
	import ntt_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [INDEX_W-1:0] index;
	logic [DATA_W-1:0] value;
	modport source(output valid, req_type, index, value, input ready);
	modport sink(input valid, req_type, index, value, output ready);
endinterface

interface ntt_rsp_if;
	import ntt_pkg::*;
	logic valid;
	logic ready;
	logic [DATA_W-1:0] read_value;
	logic done_res;
	modport source(output valid, read_value, done_res, input ready);
	modport sink(input valid, read_value, done_res, output ready);
endinterface

interface ntt_cfg_if;
	import ntt_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/ntt_modmul.sv =====
// shared modular multiplier, one operand bit per cycle, msb first
// depends on ntt_pkg
module ntt_modmul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ntt_pkg::DATA_W-1:0] a,
	input  logic [ntt_pkg::DATA_W-1:0] b,
	output logic done,
	output logic [ntt_pkg::DATA_W-1:0] res
);
	import ntt_pkg::*;

	localparam int unsigned CW = $clog2(DATA_W);

	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W:0] dbl;
	logic [DATA_W:0] dbl_red;
	logic [DATA_W:0] sum;
	logic [DATA_W:0] sum_red;

	// acc = 2*acc + bit*a, each kept below the modulus by one conditional subtract
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, MODULUS}) ? dbl - {1'b0, MODULUS} : dbl;
		sum = dbl_red + (b_q[DATA_W-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= {1'b0, MODULUS}) ? sum - {1'b0, MODULUS} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= sum_red[DATA_W-1:0];
			b_q <= {b_q[DATA_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res = acc_q;

endmodule

// ===== rtl/ntt_transform_engine.sv =====
// top level: coefficient memory, transform sequencer and the shared multiplier
// depends on ntt_pkg, ntt_ifs and ntt_modmul
// transform: bit-reversal permutation, then log2(N) stages, each computing its twiddle step
// by square-and-multiply and then doing N/2 butterflies, plus for inverse a scaling by 1/N;
// one transaction at a time, not ready while it runs
// async reset clears control and config registers; coefficient memory is not cleared
module ntt_transform_engine #(
	parameter int unsigned LOG_MAX_SIZE = 12
) (
	input  logic clk,
	input  logic arst_n,
	ntt_req_if.sink req,
	ntt_rsp_if.source rsp,
	ntt_cfg_if.sink cfg
);
	import ntt_pkg::*;

	localparam int unsigned AW = LOG_MAX_SIZE;
	localparam int unsigned DEPTH = 1 << LOG_MAX_SIZE;
	localparam int unsigned KW = $clog2(LOG_MAX_SIZE + 2);

	typedef enum logic [4:0] {
		S_IDLE, S_READ, S_DONE,
		P_CHK, P_RD2, P_W1, P_W2,
		ST_INIT, PW_CHK, PW_M1, PW_M2,
		BF_RD, BF_MUL, BF_WV, BF_WA, BF_WB, BF_WW,
		SC_INIT, SC_RD, SC_MUL, SC_W
	} state_t;

	state_t state_q;
	logic inverse_q;
	logic [3:0] log_size_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] s_q;
	logic [AW:0] i_q;
	logic [AW-1:0] j_q;
	logic [DATA_W-1:0] x_q, v_q, w_q, step_q, scale_q;
	logic [DATA_W-1:0] base_q, acc_q, exp_q;
	logic pow_scale_q;
	logic rsp_valid_q, rsp_done_q;
	logic [DATA_W-1:0] rsp_data_q;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [DATA_W-1:0] mem_wdata;

	logic mul_start, mul_done;
	logic [DATA_W-1:0] mul_a, mul_b, mul_res;

	logic req_acc, cfg_acc;
	logic [AW:0] n_full;
	logic [AW-1:0] half_n;
	logic [AW-1:0] rev_full, rev_i;
	logic i_lt_r;
	logic [AW-1:0] half_mask, pos, addr_a, addr_b;
	logic [DATA_W-1:0] load_red, exp_fwd;
	logic [DATA_W:0] add_s, sub_s;
	logic [DATA_W-1:0] add_red, sub_red;

	ntt_modmul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .res(mul_res)
	);

	assign req_acc = req.valid && req.ready;
	assign cfg_acc = cfg.valid && cfg.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.read_value = rsp_data_q;
	assign rsp.done_res = rsp_done_q;

	assign n_full = (AW+1)'(1) << k_q;
	assign half_n = AW'(n_full >> 1);

	// bit reversal over k bits: reverse all address bits, then drop the unused ones
	always_comb begin
		for (int b = 0; b < AW; b++) rev_full[b] = i_q[AW-1-b];
		rev_i = rev_full >> (KW'(AW) - k_q);
		i_lt_r = i_q < {1'b0, rev_i};
	end

	// butterfly pair for index j in stage s: group j>>(s-1), offset j mod half
	always_comb begin
		half_mask = AW'((AW+1)'(1) << (s_q - 1'b1)) - 1'b1;
		pos = j_q & half_mask;
		addr_a = ((j_q >> (s_q - 1'b1)) << s_q) | pos;
		addr_b = addr_a | (half_mask + 1'b1);
	end

	always_comb begin
		load_red = (req.value >= MODULUS) ? req.value - MODULUS : req.value;
		exp_fwd = ROOT_ODD << (TWO_ADIC - 32'(s_q));
		add_s = {1'b0, rdata_q} + {1'b0, v_q};
		add_red = (add_s >= {1'b0, MODULUS}) ? DATA_W'(add_s - {1'b0, MODULUS})
			: add_s[DATA_W-1:0];
		sub_s = (rdata_q >= v_q) ? {1'b0, rdata_q} - {1'b0, v_q}
			: {1'b0, rdata_q} + {1'b0, MODULUS} - {1'b0, v_q};
		sub_red = sub_s[DATA_W-1:0];
	end

	// memory and multiplier strobes per state
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = i_q[AW-1:0];
		mem_wdata = rdata_q;
		mul_start = 1'b0;
		mul_a = base_q;
		mul_b = base_q;
		unique case (state_q)
			S_IDLE: begin
				mem_addr = AW'(req.index);
				mem_wdata = load_red;
				mem_we = req_acc && (req.req_type == REQ_LOAD);
				mem_re = req_acc && (req.req_type == REQ_READ);
			end
			P_CHK: mem_re = (i_q != n_full) && i_lt_r;
			P_RD2: begin
				mem_re = 1'b1;
				mem_addr = rev_i;
			end
			P_W1: mem_we = 1'b1;
			P_W2: begin
				mem_we = 1'b1;
				mem_addr = rev_i;
				mem_wdata = x_q;
			end
			PW_CHK: begin
				mul_start = (exp_q != '0);
				mul_a = exp_q[0] ? acc_q : base_q;
			end
			PW_M1: mul_start = mul_done;
			BF_RD: begin
				mem_re = (j_q != half_n);
				mem_addr = addr_b;
			end
			BF_MUL: begin
				mul_start = 1'b1;
				mul_a = rdata_q;
				mul_b = w_q;
				mem_re = 1'b1;
				mem_addr = addr_a;
			end
			BF_WA: begin
				mem_we = 1'b1;
				mem_addr = addr_a;
				mem_wdata = add_red;
			end
			BF_WB: begin
				mem_we = 1'b1;
				mem_addr = addr_b;
				mem_wdata = sub_red;
				mul_start = 1'b1;
				mul_a = w_q;
				mul_b = step_q;
			end
			SC_RD: mem_re = (i_q != n_full);
			SC_MUL: begin
				mul_start = 1'b1;
				mul_a = rdata_q;
				mul_b = scale_q;
			end
			SC_W: begin
				mem_we = mul_done;
				mem_wdata = mul_res;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inverse_q <= 1'b0;
			log_size_q <= 4'd10;
			rsp_valid_q <= 1'b0;
			rsp_done_q <= 1'b0;
			rsp_data_q <= '0;
			k_q <= '0;
			s_q <= '0;
			i_q <= '0;
			j_q <= '0;
			pow_scale_q <= 1'b0;
			x_q <= '0;
			v_q <= '0;
			w_q <= '0;
			step_q <= '0;
			scale_q <= '0;
			base_q <= '0;
			acc_q <= '0;
			exp_q <= '0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg.index)
					CFG_INVERSE: inverse_q <= cfg.data[0];
					CFG_LOG_SIZE: log_size_q <= cfg.data[3:0];
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						unique case (req.req_type)
							REQ_LOAD: begin
								rsp_valid_q <= 1'b1;
								rsp_done_q <= 1'b1;
								rsp_data_q <= '0;
							end
							REQ_XFORM: begin
								k_q <= (log_size_q > LOG_MAX_SIZE) ? KW'(LOG_MAX_SIZE)
									: KW'(log_size_q);
								i_q <= '0;
								state_q <= P_CHK;
							end
							REQ_READ: state_q <= S_READ;
							default: begin
								rsp_valid_q <= 1'b1;
								rsp_done_q <= 1'b0;
								rsp_data_q <= '0;
							end
						endcase
					end
				end
				S_READ: begin
					rsp_valid_q <= 1'b1;
					rsp_done_q <= 1'b1;
					rsp_data_q <= rdata_q;
					state_q <= S_IDLE;
				end
				S_DONE: begin
					rsp_valid_q <= 1'b1;
					rsp_done_q <= 1'b1;
					rsp_data_q <= '0;
					state_q <= S_IDLE;
				end
				P_CHK: begin
					if (i_q == n_full) begin
						s_q <= KW'(1);
						state_q <= ST_INIT;
					end else if (i_lt_r) begin
						state_q <= P_RD2;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				P_RD2: begin
					x_q <= rdata_q;
					state_q <= P_W1;
				end
				P_W1: state_q <= P_W2;
				P_W2: begin
					i_q <= i_q + 1'b1;
					state_q <= P_CHK;
				end
				ST_INIT: begin
					if (s_q > k_q) begin
						state_q <= inverse_q ? SC_INIT : S_DONE;
					end else begin
						// inverse twiddle is root^(p-1-e)
						base_q <= ROOT;
						acc_q <= DATA_W'(1);
						exp_q <= inverse_q ? MODULUS - DATA_W'(1) - exp_fwd : exp_fwd;
						pow_scale_q <= 1'b0;
						state_q <= PW_CHK;
					end
				end
				PW_CHK: begin
					if (exp_q == '0) begin
						j_q <= '0;
						i_q <= '0;
						if (pow_scale_q) begin
							scale_q <= acc_q;
							state_q <= SC_RD;
						end else begin
							step_q <= acc_q;
							state_q <= BF_RD;
						end
					end else begin
						state_q <= exp_q[0] ? PW_M1 : PW_M2;
					end
				end
				PW_M1: begin
					if (mul_done) begin
						acc_q <= mul_res;
						state_q <= PW_M2;
					end
				end
				PW_M2: begin
					if (mul_done) begin
						base_q <= mul_res;
						exp_q <= exp_q >> 1;
						state_q <= PW_CHK;
					end
				end
				BF_RD: begin
					if (j_q == half_n) begin
						s_q <= s_q + 1'b1;
						state_q <= ST_INIT;
					end else begin
						if (pos == '0) w_q <= DATA_W'(1);
						state_q <= BF_MUL;
					end
				end
				BF_MUL: state_q <= BF_WV;
				BF_WV: begin
					if (mul_done) begin
						v_q <= mul_res;
						state_q <= BF_WA;
					end
				end
				BF_WA: state_q <= BF_WB;
				BF_WB: state_q <= BF_WW;
				BF_WW: begin
					if (mul_done) begin
						w_q <= mul_res;
						j_q <= j_q + 1'b1;
						state_q <= BF_RD;
					end
				end
				SC_INIT: begin
					base_q <= DATA_W'(n_full);
					acc_q <= DATA_W'(1);
					exp_q <= MODULUS - DATA_W'(2);
					pow_scale_q <= 1'b1;
					state_q <= PW_CHK;
				end
				SC_RD: state_q <= (i_q == n_full) ? S_DONE : SC_MUL;
				SC_MUL: state_q <= SC_W;
				SC_W: begin
					if (mul_done) begin
						i_q <= i_q + 1'b1;
						state_q <= SC_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a new response only comes from the states that complete a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !$past(rsp_valid_q)) |->
		($past(state_q) == S_IDLE || $past(state_q) == S_READ || $past(state_q) == S_DONE))
		else $error("response raised outside a completing state");

	// the memory is never written while waiting on the multiplier for an operand
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !(state_q == PW_M1 || state_q == PW_M2 || state_q == BF_WV
		|| state_q == BF_WW))
		else $error("memory write during multiplier wait");

	// the shared multiplier is started at most once per finished product
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> !mul_start)
		else $error("multiplier restarted back to back");

endmodule

// ===== bench/ntt_checker.sv =====
// result checker for the transform engine: watches request, response and config writes,
// keeps its own coefficient store and compares every response in order
// depends on ntt_pkg and ntt_ifs
module ntt_checker (
	input  logic clk,
	input  logic arst_n,
	ntt_req_if req,
	ntt_rsp_if rsp,
	ntt_cfg_if cfg,
	output int   fail_count,
	output int   pending
);
	import ntt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned PRIME = 64'd2281701377;
	localparam int unsigned DEPTH = 1 << INDEX_W;
	localparam int unsigned LOG_MAX = INDEX_W;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic              done_res;
	} coef_result_t;

	coef_result_t      expected_results[$];
	logic [DATA_W-1:0] coef_mirror[DEPTH];
	logic              inv_mode;
	logic [3:0]        size_log;

	assign pending = expected_results.size();

	function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b);
		return (a * b) % PRIME;
	endfunction

	function automatic longint unsigned powmod(longint unsigned b, longint unsigned e);
		longint unsigned acc;
		longint unsigned sq;
		acc = 1;
		sq = b % PRIME;
		while (e != 0) begin
			if (e[0]) acc = mulmod(acc, sq);
			sq = mulmod(sq, sq);
			e = e >> 1;
		end
		return acc;
	endfunction

	task automatic transform_mirror();
		int unsigned k, n, r, len, half, st, pos;
		longint unsigned step, w, u, v, scale;
		logic [DATA_W-1:0] t;
		k = (size_log > LOG_MAX) ? LOG_MAX : size_log;
		n = 1 << k;
		// bit-reversal permutation
		for (int unsigned i = 0; i < n; i++) begin
			r = 0;
			for (int unsigned b = 0; b < k; b++) r |= ((i >> b) & 1) << (k - 1 - b);
			if (i < r) begin
				t = coef_mirror[i];
				coef_mirror[i] = coef_mirror[r];
				coef_mirror[r] = t;
			end
		end
		for (len = 2; len <= n; len = len << 1) begin
			step = powmod(64'd3, (PRIME - 1) / len);
			if (inv_mode) step = powmod(step, PRIME - 2);
			half = len >> 1;
			for (st = 0; st < n; st += len) begin
				w = 1;
				for (pos = 0; pos < half; pos++) begin
					u = coef_mirror[st + pos];
					v = mulmod(coef_mirror[st + pos + half], w);
					coef_mirror[st + pos] = DATA_W'((u + v) % PRIME);
					coef_mirror[st + pos + half] = DATA_W'((u + PRIME - v) % PRIME);
					w = mulmod(w, step);
				end
			end
		end
		if (inv_mode) begin
			scale = powmod(n, PRIME - 2);
			for (int unsigned i = 0; i < n; i++)
				coef_mirror[i] = DATA_W'(mulmod(coef_mirror[i], scale));
		end
	endtask

	task automatic apply_request(logic [1:0] kind, logic [INDEX_W-1:0] idx,
			logic [DATA_W-1:0] val);
		coef_result_t res;
		longint unsigned v;
		res = '0;
		case (kind)
			REQ_LOAD: begin
				v = val;
				if (v >= PRIME) v = v - PRIME;
				coef_mirror[idx] = DATA_W'(v);
				res.done_res = 1'b1;
			end
			REQ_XFORM: begin
				transform_mirror();
				res.done_res = 1'b1;
			end
			REQ_READ: begin
				res.read_value = coef_mirror[idx];
				res.done_res = 1'b1;
			end
			default: ;
		endcase
		expected_results.push_back(res);
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) coef_mirror[i] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		coef_result_t want;
		if (!arst_n) begin
			inv_mode <= 1'b0;
			size_log <= 4'd10;
			fail_count <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected response value=%0d done=%0b", $realtime,
							rsp.read_value, rsp.done_res);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.read_value !== rsp.read_value || want.done_res !== rsp.done_res) begin
						if (fail_count < 10)
							$display("%0t: response mismatch expected value=%0d done=%0b got value=%0d done=%0b",
								$realtime, want.read_value, want.done_res, rsp.read_value,
								rsp.done_res);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req.valid && req.ready) apply_request(req.req_type, req.index, req.value);
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_INVERSE: inv_mode <= cfg.data[0];
					CFG_LOG_SIZE: size_log <= cfg.data[3:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
// stimulus and verdict for the transform engine: loads, transforms and reads over a
// series of size and direction settings, with random stalls on both sides
// depends on ntt_pkg, ntt_ifs, ntt_checker and the engine rtl
module testbench;
	import ntt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 800000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic [DATA_W-1:0] P = MODULUS;

	logic clk;
	logic arst_n;
	logic quiet;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	logic written[1 << INDEX_W];
	int   written_list[$];

	ntt_req_if req_ch();
	ntt_rsp_if rsp_ch();
	ntt_cfg_if cfg_ch();

	ntt_transform_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	ntt_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side back-pressure
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic issue_request(logic [1:0] kind, int unsigned idx,
			logic [DATA_W-1:0] val);
		logic [INDEX_W-1:0] slot;
		slot = INDEX_W'(idx);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.index <= slot;
		req_ch.value <= val;
		do @(posedge clk); while (!req_ch.ready);
		if (kind == REQ_LOAD && !written[slot]) begin
			written[slot] = 1'b1;
			written_list.push_back(int'(slot));
		end
	endtask

	// stop sending and wait for every outstanding response
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t which, logic [3:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= which;
		cfg_ch.data <= ($urandom() & ~32'hf) | v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic read_written();
		issue_request(REQ_READ, written_list[$urandom_range(0, written_list.size() - 1)],
			$urandom());
	endtask

	task automatic run_phase(logic inv, logic [3:0] lg, int extra, int max_xforms,
			logic wide_index);
		int n, pick, xforms;
		logic [DATA_W-1:0] val;
		n = 1 << ((lg > INDEX_W) ? INDEX_W : lg);
		xforms = 0;
		write_reg(CFG_INVERSE, 4'(inv));
		write_reg(CFG_LOG_SIZE, lg);
		for (int i = 0; i < n; i++) issue_request(REQ_LOAD, i, $urandom_range(0, P - 1));
		for (int i = 0; i < extra; i++) begin
			pick = $urandom_range(0, 99);
			val = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, P - 1);
			if (pick < 6 && xforms < max_xforms) begin
				issue_request(REQ_XFORM, $urandom(), $urandom());
				xforms++;
			end else if (pick < 40)
				issue_request(REQ_LOAD, wide_index ? $urandom() : $urandom_range(0, n - 1), val);
			else if (pick < 45)
				issue_request(REQ_UNKNOWN, $urandom(), $urandom());
			else
				read_written();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		quiet = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.index = '0;
		req_ch.value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_INVERSE;
		cfg_ch.data = '0;
		for (int i = 0; i < (1 << INDEX_W); i++) written[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// size one, unreduced values, unknown request, top of the store
		write_reg(CFG_INVERSE, 4'd0);
		write_reg(CFG_LOG_SIZE, 4'd0);
		issue_request(REQ_LOAD, 0, 32'hffffffff);
		issue_request(REQ_XFORM, 0, 0);
		issue_request(REQ_READ, 0, 0);
		issue_request(REQ_UNKNOWN, 12'hfff, 32'hffffffff);
		issue_request(REQ_LOAD, 12'hfff, P);
		issue_request(REQ_READ, 12'hfff, 0);
		issue_request(REQ_LOAD, 12'h800, 32'h0);
		issue_request(REQ_READ, 12'h800, 32'hffffffff);
		// two points forward then back, then four points forward
		write_reg(CFG_LOG_SIZE, 4'd1);
		issue_request(REQ_LOAD, 1, P - 1);
		issue_request(REQ_LOAD, 0, 5);
		issue_request(REQ_XFORM, 0, 0);
		issue_request(REQ_READ, 0, 0);
		issue_request(REQ_READ, 1, 0);
		write_reg(CFG_INVERSE, 4'd1);
		issue_request(REQ_XFORM, 0, 0);
		issue_request(REQ_READ, 0, 0);
		issue_request(REQ_READ, 1, 0);
		write_reg(CFG_INVERSE, 4'd0);
		write_reg(CFG_LOG_SIZE, 4'd2);
		issue_request(REQ_LOAD, 2, $urandom_range(0, P - 1));
		issue_request(REQ_LOAD, 3, $urandom_range(0, P - 1));
		issue_request(REQ_XFORM, 0, 0);
		issue_request(REQ_READ, 2, 0);
		issue_request(REQ_READ, 3, 0);

		run_phase(1'b0, 4'd3, 40, 3, 1'b0);
		run_phase(1'b1, 4'd3, 40, 3, 1'b1);
		run_phase(1'b0, 4'd5, 20, 2, 1'b0);
		drain();
		issue_request(REQ_XFORM, 0, 0);
		run_phase(1'b1, 4'd4, 40, 3, 1'b0);
		run_phase(1'b0, 4'd6, 20, 1, 1'b0);
		issue_request(REQ_XFORM, 0, 0);
		run_phase(1'b1, 4'd6, 20, 1, 1'b0);
		// larger size with loads spread over the whole index range
		run_phase(1'b0, 4'd7, 20, 1, 1'b1);
		run_phase(1'b1, 4'd2, 40, 3, 1'b1);
		quiet = 1'b1;
		run_phase(1'b0, 4'd5, 50, 1, 1'b0);

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ntt_pkg.sv
rtl/ntt_ifs.sv
rtl/ntt_modmul.sv
rtl/ntt_transform_engine.sv
bench/ntt_checker.sv
bench/testbench.sv
